### hw/rtl/lers_pkg.sv
// Package: shared constants and types of the edge rule sequencer.
`timescale 1ns / 1ps
package lers_pkg;

	localparam int LERS_ENTRIES   = 64;
	localparam int LERS_IN_WIDTH  = 8;
	localparam int LERS_OUT_WIDTH = 16;
	localparam int PAGE_W         = 8;

	localparam logic [2:0] CMD_STEP     = 3'd0;
	localparam logic [2:0] CMD_LEARN    = 3'd1;
	localparam logic [2:0] CMD_REM_NEAR = 3'd2;
	localparam logic [2:0] CMD_REM_PAGE = 3'd3;
	localparam logic [2:0] CMD_CLEAR    = 3'd4;
	localparam logic [2:0] CMD_SET_OUT  = 3'd5;
	localparam logic [2:0] CMD_SET_PAGE = 3'd6;

	localparam logic [3:0] ST_NONE     = 4'd0;
	localparam logic [3:0] ST_NOTFOUND = 4'd1;
	localparam logic [3:0] ST_GLOBAL   = 4'd2;
	localparam logic [3:0] ST_CURRENT  = 4'd3;
	localparam logic [3:0] ST_ABOVE    = 4'd4;
	localparam logic [3:0] ST_BELOW    = 4'd5;
	localparam logic [3:0] ST_STORED   = 4'd6;
	localparam logic [3:0] ST_FULL     = 4'd7;
	localparam logic [3:0] ST_EXISTS   = 4'd8;
	localparam logic [3:0] ST_DONE     = 4'd9;

	localparam logic [PAGE_W-1:0] PAGE_EMPTY  = 8'd0;
	localparam logic [PAGE_W-1:0] PAGE_GLOBAL = 8'd1;

	typedef struct packed {
		logic [3:0] status;
		logic       hit;
	} scan_res_t;

endpackage

### hw/rtl/lers_if.sv
// Interfaces: command item channel and result item channel.
`timescale 1ns / 1ps
interface lers_cmd_if;
	logic        valid;
	logic        ready;
	logic [2:0]  command;
	logic [7:0]  input_pattern;
	logic [15:0] target_output;
	logic [15:0] rule_mask;
	logic [7:0]  rule_page;
	modport source (output valid, command, input_pattern, target_output, rule_mask, rule_page,
		input ready);
	modport sink (input valid, command, input_pattern, target_output, rule_mask, rule_page,
		output ready);
endinterface

interface lers_res_if;
	logic        valid;
	logic        ready;
	logic [3:0]  status;
	logic [15:0] output_word;
	logic [7:0]  current_page;
	logic [6:0]  used_count;
	modport source (output valid, status, output_word, current_page, used_count, input ready);
	modport sink (input valid, status, output_word, current_page, used_count, output ready);
endinterface

### hw/rtl/learned_edge_rule_sequencer_unit.sv
// Edge rule sequencer: rule entries in a rotating ring of cells, one scan unit at the head.
// Table commands (step, learn, remove) with an edge search the whole ring in S_SCAN, settle
// the result in S_APPLY and turn the ring again there only when an entry is written or
// applied; S_DONE then waits for a free result slot. Other commands, those with no edge, and
// learn or remove by page with page zero go straight to S_DONE. One item is in work at a time.
// Reset empties all entries and zeroes latched input, output, page and count at once.
`timescale 1ns / 1ps
module learned_edge_rule_sequencer_unit
	import lers_pkg::*;
#(
	parameter int ENTRIES   = LERS_ENTRIES,
	parameter int IN_WIDTH  = LERS_IN_WIDTH,
	parameter int OUT_WIDTH = LERS_OUT_WIDTH
) (
	input  logic   clk,
	input  logic   arst_n,
	lers_cmd_if.sink   in_ch,
	lers_res_if.source out_ch
);
	localparam int IXW = $clog2(ENTRIES);
	localparam int CW  = $clog2(ENTRIES + 1);
	localparam int EGW = 2 * IN_WIDTH;
	localparam int EW  = PAGE_W + EGW + 4 * OUT_WIDTH;
	localparam logic [IXW-1:0] LAST = IXW'(ENTRIES - 1);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SCAN  = 2'd1;
	localparam logic [1:0] S_APPLY = 2'd2;
	localparam logic [1:0] S_DONE  = 2'd3;

	logic [1:0]           state_q;
	logic [IXW-1:0]       idx_q;
	logic [2:0]           cmd_q;
	logic [IN_WIDTH-1:0]  pat_q, latched_q;
	logic [EGW-1:0]       edges_q;
	logic [OUT_WIDTH-1:0] tgt_q, mask_q, outb_q;
	logic [PAGE_W-1:0]    rpage_q, apage_q;
	logic [CW-1:0]        count_q;
	logic [3:0]           status_q;

	logic                 out_valid_q;
	logic [3:0]           o_status_q;
	logic [15:0]          o_word_q;
	logic [7:0]           o_page_q;
	logic [6:0]           o_count_q;

	logic [15:0]          pat16;
	logic [IN_WIDTH-1:0]  pat_in;
	logic [EGW-1:0]       edges_in;
	logic                 accept, go_scan, slot_free, finish, at_hit;
	logic [EW-1:0]        ring [ENTRIES];
	logic [EW-1:0]        head, tail_in, new_entry;
	logic                 shift, clr_all;
	scan_res_t            sres;
	logic [IXW-1:0]       hit_idx;
	logic [OUT_WIDTH-1:0] h_m, h_clr, h_set, clr_n, set_n, out_next;
	logic [OUT_WIDTH+15:0] word_ext;
	logic [CW+6:0]        cnt_ext;

	assign in_ch.ready = (state_q == S_IDLE);
	assign accept      = in_ch.valid && in_ch.ready;
	assign pat16       = {8'd0, in_ch.input_pattern};
	assign pat_in      = pat16[IN_WIDTH-1:0];
	assign edges_in    = {latched_q & ~pat_in, pat_in & ~latched_q};
	assign go_scan     = (edges_in != '0) &&
		(((in_ch.command == CMD_STEP) || (in_ch.command == CMD_REM_NEAR)) ||
		(((in_ch.command == CMD_LEARN) || (in_ch.command == CMD_REM_PAGE)) &&
		(in_ch.rule_page != PAGE_EMPTY)));
	assign slot_free   = !out_valid_q || out_ch.ready;
	assign finish      = (state_q == S_DONE) && slot_free;
	// the second turn only runs when the scan found something to write or apply
	assign shift       = (state_q == S_SCAN) || ((state_q == S_APPLY) && sres.hit);
	assign clr_all     = finish && (cmd_q == CMD_CLEAR);
	assign head        = ring[0];
	assign at_hit      = (state_q == S_APPLY) && sres.hit && (idx_q == hit_idx);

	// new rule for learn; local rules store only the bits that change
	always_comb begin
		if (rpage_q > PAGE_GLOBAL) begin
			clr_n = outb_q & ~tgt_q & mask_q;
			set_n = ~outb_q & tgt_q & mask_q;
		end else begin
			clr_n = ~tgt_q & mask_q;
			set_n = tgt_q & mask_q;
		end
		new_entry = {rpage_q, edges_q, outb_q, mask_q, clr_n, set_n};
	end

	always_comb begin
		tail_in = head;
		if (at_hit) begin
			case (cmd_q)
				CMD_LEARN:                 tail_in = new_entry;
				CMD_REM_NEAR, CMD_REM_PAGE: tail_in = {PAGE_EMPTY, head[EW-PAGE_W-1:0]};
				default:                   tail_in = head;
			endcase
		end
	end

	assign h_m      = head[3*OUT_WIDTH-1 -: OUT_WIDTH];
	assign h_clr    = head[2*OUT_WIDTH-1 -: OUT_WIDTH];
	assign h_set    = head[OUT_WIDTH-1:0];
	assign out_next = (outb_q | (h_set & h_m)) & ~(h_clr & h_m);

	genvar g;
	generate
		for (g = 0; g < ENTRIES; g++) begin : g_ring
			lers_cell #(.EW(EW)) u_cell (
				.clk   (clk),
				.arst_n(arst_n),
				.shift (shift),
				.clr   (clr_all),
				.din   ((g == ENTRIES - 1) ? tail_in : ring[(g + 1) % ENTRIES]),
				.dout  (ring[g])
			);
		end
	endgenerate

	lers_scan #(.ENTRIES(ENTRIES), .IN_WIDTH(IN_WIDTH), .OUT_WIDTH(OUT_WIDTH)) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.en     (state_q == S_SCAN),
		.idx    (idx_q),
		.head   (head),
		.cmd    (cmd_q),
		.edges  (edges_q),
		.rpage  (rpage_q),
		.rmask  (mask_q),
		.apage  (apage_q),
		.outb   (outb_q),
		.res    (sres),
		.hit_idx(hit_idx)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= in_ch.command;
			pat_q   <= pat_in;
			edges_q <= edges_in;
			tgt_q   <= in_ch.target_output[OUT_WIDTH-1:0];
			mask_q  <= in_ch.rule_mask[OUT_WIDTH-1:0];
			rpage_q <= in_ch.rule_page;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			idx_q     <= '0;
			status_q  <= ST_NONE;
			latched_q <= '0;
			outb_q    <= '0;
			apage_q   <= PAGE_EMPTY;
			count_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						idx_q    <= '0;
						state_q  <= go_scan ? S_SCAN : S_DONE;
						if (in_ch.command == CMD_CLEAR || in_ch.command == CMD_SET_OUT ||
							in_ch.command == CMD_SET_PAGE) begin
							status_q <= ST_DONE;
						end else begin
							status_q <= ST_NONE;
						end
					end
				end
				S_SCAN: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == LAST) begin
						idx_q   <= '0;
						state_q <= S_APPLY;
					end
				end
				S_APPLY: begin
					// scan trackers hold their result from here on
					status_q <= sres.status;
					if (!sres.hit) begin
						state_q <= S_DONE;
					end else begin
						idx_q <= idx_q + 1'b1;
						if (at_hit) begin
							case (cmd_q)
								CMD_STEP: begin
									outb_q  <= out_next;
									apage_q <= head[EW-1 -: PAGE_W];
								end
								CMD_LEARN:                  count_q <= count_q + 1'b1;
								CMD_REM_NEAR, CMD_REM_PAGE: count_q <= count_q - 1'b1;
								default: ;
							endcase
						end
						if (idx_q == LAST) state_q <= S_DONE;
					end
				end
				default: begin
					if (slot_free) begin
						state_q <= S_IDLE;
						case (cmd_q)
							CMD_STEP:     if (edges_q != '0) latched_q <= pat_q;
							CMD_CLEAR: begin
								outb_q  <= '0;
								count_q <= '0;
							end
							CMD_SET_OUT:  outb_q  <= tgt_q;
							CMD_SET_PAGE: apage_q <= rpage_q;
							default: ;
						endcase
					end
				end
			endcase
		end
	end

	// result reflects the updates made in the same finishing cycle
	always_comb begin
		word_ext = {16'd0, outb_q};
		cnt_ext  = {7'd0, count_q};
		case (cmd_q)
			CMD_CLEAR: begin
				word_ext = '0;
				cnt_ext  = '0;
			end
			CMD_SET_OUT: word_ext = {16'd0, tgt_q};
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			o_status_q <= status_q;
			o_word_q   <= word_ext[15:0];
			o_page_q   <= (cmd_q == CMD_SET_PAGE) ? rpage_q : apage_q;
			o_count_q  <= cnt_ext[6:0];
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.status       = o_status_q;
	assign out_ch.output_word  = o_word_q;
	assign out_ch.current_page = o_page_q;
	assign out_ch.used_count   = o_count_q;
endmodule

### hw/rtl/lers_cell.sv
// One rule entry of the rotating ring; page field on top, empty when zero.
`timescale 1ns / 1ps
module lers_cell
	import lers_pkg::*;
#(
	parameter int EW = 88
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          shift,
	input  logic          clr,
	input  logic [EW-1:0] din,
	output logic [EW-1:0] dout
);
	logic [PAGE_W-1:0]    page_q;
	logic [EW-PAGE_W-1:0] body_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_q <= PAGE_EMPTY;
		end else if (clr) begin
			page_q <= PAGE_EMPTY;
		end else if (shift) begin
			page_q <= din[EW-1 -: PAGE_W];
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			body_q <= din[EW-PAGE_W-1:0];
		end
	end

	assign dout = {page_q, body_q};
endmodule

### hw/rtl/lers_scan.sv
// Scan unit: watches the ring head pass by and tracks the winning entry.
`timescale 1ns / 1ps
module lers_scan
	import lers_pkg::*;
#(
	parameter int ENTRIES   = LERS_ENTRIES,
	parameter int IN_WIDTH  = LERS_IN_WIDTH,
	parameter int OUT_WIDTH = LERS_OUT_WIDTH,
	localparam int IXW = $clog2(ENTRIES),
	localparam int EGW = 2 * IN_WIDTH,
	localparam int EW  = PAGE_W + EGW + 4 * OUT_WIDTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 en,
	input  logic [IXW-1:0]       idx,
	input  logic [EW-1:0]        head,
	input  logic [2:0]           cmd,
	input  logic [EGW-1:0]       edges,
	input  logic [PAGE_W-1:0]    rpage,
	input  logic [OUT_WIDTH-1:0] rmask,
	input  logic [PAGE_W-1:0]    apage,
	input  logic [OUT_WIDTH-1:0] outb,
	output scan_res_t            res,
	output logic [IXW-1:0]       hit_idx
);
	logic [PAGE_W-1:0]    pg;
	logic [EGW-1:0]       h_edges;
	logic [OUT_WIDTH-1:0] fb, m;
	logic                 eq, fits, fits_r;
	logic [PAGE_W-1:0]    d_up, d_dn;

	logic                 imm_q, up_q, dn_q, exists_q, empty_q;
	logic [3:0]           imm_st_q;
	logic [IXW-1:0]       imm_idx_q, up_idx_q, dn_idx_q, empty_idx_q;
	logic [PAGE_W-1:0]    up_d_q, dn_d_q;

	assign pg      = head[EW-1 -: PAGE_W];
	assign h_edges = head[EW-PAGE_W-1 -: EGW];
	assign fb      = head[4*OUT_WIDTH-1 -: OUT_WIDTH];
	assign m       = head[3*OUT_WIDTH-1 -: OUT_WIDTH];
	assign eq      = (pg != PAGE_EMPTY) && (h_edges == edges);
	assign fits    = (fb & m) == (outb & m);
	assign fits_r  = (fb & rmask) == (outb & rmask);
	assign d_up    = pg - apage;
	assign d_dn    = apage - pg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			imm_q    <= 1'b0;
			up_q     <= 1'b0;
			dn_q     <= 1'b0;
			exists_q <= 1'b0;
			empty_q  <= 1'b0;
		end else if (start) begin
			imm_q    <= 1'b0;
			up_q     <= 1'b0;
			dn_q     <= 1'b0;
			exists_q <= 1'b0;
			empty_q  <= 1'b0;
		end else if (en) begin
			case (cmd)
				CMD_STEP, CMD_REM_NEAR: begin
					if (!imm_q && eq) begin
						if (pg == PAGE_GLOBAL) begin
							imm_q <= 1'b1;
						end else if (fits && pg == apage) begin
							imm_q <= 1'b1;
						end else if (fits && pg > apage) begin
							if (!up_q || d_up < up_d_q) up_q <= 1'b1;
						end else if (fits) begin
							if (!dn_q || d_dn < dn_d_q) dn_q <= 1'b1;
						end
					end
				end
				CMD_LEARN: begin
					if (eq && (pg == PAGE_GLOBAL || (pg == rpage && fits_r))) exists_q <= 1'b1;
					if (pg == PAGE_EMPTY) empty_q <= 1'b1;
				end
				CMD_REM_PAGE: begin
					if (!imm_q && eq && pg == rpage && (rpage == PAGE_GLOBAL || fits))
						imm_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// payload side of the trackers, qualified by the flags above
	always_ff @(posedge clk) begin
		if (en) begin
			case (cmd)
				CMD_STEP, CMD_REM_NEAR: begin
					if (!imm_q && eq) begin
						if (pg == PAGE_GLOBAL) begin
							imm_st_q  <= ST_GLOBAL;
							imm_idx_q <= idx;
						end else if (fits && pg == apage) begin
							imm_st_q  <= ST_CURRENT;
							imm_idx_q <= idx;
						end else if (fits && pg > apage) begin
							if (!up_q || d_up < up_d_q) begin
								up_d_q   <= d_up;
								up_idx_q <= idx;
							end
						end else if (fits) begin
							if (!dn_q || d_dn < dn_d_q) begin
								dn_d_q   <= d_dn;
								dn_idx_q <= idx;
							end
						end
					end
				end
				CMD_LEARN: begin
					if (pg == PAGE_EMPTY && !empty_q) empty_idx_q <= idx;
				end
				CMD_REM_PAGE: begin
					if (!imm_q && eq && pg == rpage && (rpage == PAGE_GLOBAL || fits)) begin
						imm_st_q  <= (rpage == PAGE_GLOBAL) ? ST_GLOBAL : ST_CURRENT;
						imm_idx_q <= idx;
					end
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		res.status = ST_NOTFOUND;
		res.hit    = 1'b0;
		hit_idx    = imm_idx_q;
		if (cmd == CMD_LEARN) begin
			hit_idx = empty_idx_q;
			if (exists_q) begin
				res.status = ST_EXISTS;
			end else if (empty_q) begin
				res.status = ST_STORED;
				res.hit    = 1'b1;
			end else begin
				res.status = ST_FULL;
			end
		end else if (imm_q) begin
			res.status = imm_st_q;
			res.hit    = 1'b1;
		end else if (up_q) begin
			res.status = ST_ABOVE;
			res.hit    = 1'b1;
			hit_idx    = up_idx_q;
		end else if (dn_q) begin
			res.status = ST_BELOW;
			res.hit    = 1'b1;
			hit_idx    = dn_idx_q;
		end
	end
endmodule

### hw/rtl/lers_checker.sv
// Port checker for the edge rule sequencer, bound to the top level.
`timescale 1ns / 1ps
module lers_checker
	import lers_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [3:0]  status,
	input logic [15:0] output_word
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(output_word))
		else $error("result item changed while stalled");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item taken while one is in work");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= ST_DONE)
		else $error("status code out of range");

	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared without an item in work");
endmodule

bind learned_edge_rule_sequencer_unit lers_checker u_lers_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_ch.valid),
	.in_ready   (in_ch.ready),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.status     (out_ch.status),
	.output_word(out_ch.output_word)
);

### tb/learned_edge_rule_sequencer_unit_tb.sv
// Testbench: directed table, table fill, then random commands, checked against an in-bench rule table model.
`timescale 1ns / 1ps
module learned_edge_rule_sequencer_unit_tb;
	import lers_pkg::*;

	localparam int NE = LERS_ENTRIES;

	typedef struct packed {
		logic [3:0]  status;
		logic [15:0] output_word;
		logic [7:0]  current_page;
		logic [6:0]  used_count;
	} seq_res_t;

	typedef struct {
		logic [2:0]  cmd;
		logic [7:0]  pat;
		logic [15:0] tgt;
		logic [15:0] msk;
		logic [7:0]  pg;
		bit          typed;
		seq_res_t    res;
	} cmd_row_t;

	logic clk;
	logic arst_n;
	lers_cmd_if cmd_ch();
	lers_res_if res_ch();

	learned_edge_rule_sequencer_unit u_dut (
		.clk(clk), .arst_n(arst_n), .in_ch(cmd_ch.sink), .out_ch(res_ch.source)
	);

	// shadow rule table
	logic [7:0]  tbl_page [NE];
	logic [15:0] tbl_edges[NE];
	logic [15:0] tbl_fb   [NE];
	logic [15:0] tbl_mask [NE];
	logic [15:0] tbl_clr  [NE];
	logic [15:0] tbl_set  [NE];
	logic [7:0]  m_latched;
	logic [15:0] m_out;
	logic [7:0]  m_page;
	logic [6:0]  m_used;

	seq_res_t expected_q[$];
	int errors = 0;
	bit hold_off = 0;
	bit sending_done = 0;

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic logic [15:0] edges_of(logic [7:0] p);
		return {m_latched & ~p, p & ~m_latched};
	endfunction

	function automatic logic [3:0] rule_search(logic [15:0] e, output int hit);
		bit up_f, dn_f;
		int up_d, dn_d, up_i, dn_i, d;
		up_f = 0; dn_f = 0; up_d = 0; dn_d = 0; up_i = 0; dn_i = 0; hit = 0;
		for (int i = 0; i < NE; i++) begin
			if (tbl_page[i] == PAGE_EMPTY || tbl_edges[i] != e) continue;
			if (tbl_page[i] == PAGE_GLOBAL) begin
				hit = i;
				return ST_GLOBAL;
			end
			if ((tbl_fb[i] & tbl_mask[i]) != (m_out & tbl_mask[i])) continue;
			if (tbl_page[i] == m_page) begin
				hit = i;
				return ST_CURRENT;
			end
			if (tbl_page[i] > m_page) begin
				d = tbl_page[i] - m_page;
				if (!up_f || d < up_d) begin
					up_f = 1; up_d = d; up_i = i;
				end
			end else begin
				d = m_page - tbl_page[i];
				if (!dn_f || d < dn_d) begin
					dn_f = 1; dn_d = d; dn_i = i;
				end
			end
		end
		if (up_f) begin
			hit = up_i;
			return ST_ABOVE;
		end
		if (dn_f) begin
			hit = dn_i;
			return ST_BELOW;
		end
		return ST_NOTFOUND;
	endfunction

	function automatic void drop_entry(int i);
		if (tbl_page[i] != PAGE_EMPTY && m_used > 0) m_used--;
		tbl_page[i] = PAGE_EMPTY;
	endfunction

	function automatic seq_res_t sequencer_next(cmd_row_t r);
		logic [3:0]  st;
		logic [15:0] e;
		int hit;
		bit found;
		seq_res_t o;
		st = ST_NONE;
		e = edges_of(r.pat);
		case (r.cmd)
			CMD_STEP: if (e != 0) begin
				st = rule_search(e, hit);
				m_latched = r.pat;
				if (st >= ST_GLOBAL) begin
					m_page = tbl_page[hit];
					m_out = (m_out | (tbl_set[hit] & tbl_mask[hit])) & ~(tbl_clr[hit] & tbl_mask[hit]);
				end
			end
			CMD_LEARN: if (r.pg != 0 && e != 0) begin
				found = 0;
				for (int i = 0; i < NE; i++)
					if (tbl_page[i] != PAGE_EMPTY && tbl_edges[i] == e &&
							(tbl_page[i] == PAGE_GLOBAL || (tbl_page[i] == r.pg &&
							(tbl_fb[i] & r.msk) == (m_out & r.msk)))) found = 1;
				if (found) st = ST_EXISTS;
				else begin
					st = ST_FULL;
					for (int i = 0; i < NE; i++) begin
						if (tbl_page[i] == PAGE_EMPTY) begin
							if (r.pg > 1) begin
								tbl_clr[i] = m_out & ~r.tgt & r.msk;
								tbl_set[i] = ~m_out & r.tgt & r.msk;
							end else begin
								tbl_clr[i] = ~r.tgt & r.msk;
								tbl_set[i] = r.tgt & r.msk;
							end
							tbl_page[i] = r.pg;
							tbl_edges[i] = e;
							tbl_fb[i] = m_out;
							tbl_mask[i] = r.msk;
							m_used++;
							st = ST_STORED;
							break;
						end
					end
				end
			end
			CMD_REM_NEAR: if (e != 0) begin
				st = rule_search(e, hit);
				if (st >= ST_GLOBAL) drop_entry(hit);
			end
			CMD_REM_PAGE: if (r.pg != 0 && e != 0) begin
				st = ST_NOTFOUND;
				for (int i = 0; i < NE; i++) begin
					if (tbl_page[i] != r.pg || tbl_edges[i] != e) continue;
					if (r.pg == PAGE_GLOBAL) st = ST_GLOBAL;
					else if ((tbl_fb[i] & tbl_mask[i]) == (m_out & tbl_mask[i])) st = ST_CURRENT;
					if (st != ST_NOTFOUND) begin
						drop_entry(i);
						break;
					end
				end
			end
			CMD_CLEAR: begin
				for (int i = 0; i < NE; i++) tbl_page[i] = PAGE_EMPTY;
				m_used = 0;
				m_out = 0;
				st = ST_DONE;
			end
			CMD_SET_OUT: begin
				m_out = r.tgt;
				st = ST_DONE;
			end
			CMD_SET_PAGE: begin
				m_page = r.pg;
				st = ST_DONE;
			end
			default: ;
		endcase
		o.status = st;
		o.output_word = m_out;
		o.current_page = m_page;
		o.used_count = m_used;
		return o;
	endfunction

	task automatic send_cmd(cmd_row_t r);
		seq_res_t e;
		cmd_ch.valid <= 1;
		cmd_ch.command <= r.cmd;
		cmd_ch.input_pattern <= r.pat;
		cmd_ch.target_output <= r.tgt;
		cmd_ch.rule_mask <= r.msk;
		cmd_ch.rule_page <= r.pg;
		do @(posedge clk); while (!cmd_ch.ready);
		e = sequencer_next(r);
		if (r.typed && e != r.res) begin
			errors++;
			$display("table row disagrees with model: %h vs %h", r.res, e);
		end
		expected_q.push_back(r.typed ? r.res : e);
	endtask

	task automatic idle_cycles(int n);
		cmd_ch.valid <= 0;
		repeat (n) @(posedge clk);
	endtask

	function automatic cmd_row_t mk(logic [2:0] c, logic [7:0] p, logic [15:0] t,
			logic [15:0] m, logic [7:0] g);
		cmd_row_t r;
		r.cmd = c; r.pat = p; r.tgt = t; r.msk = m; r.pg = g; r.typed = 0; r.res = '0;
		return r;
	endfunction

	function automatic cmd_row_t mkx(cmd_row_t r, seq_res_t x);
		r.typed = 1;
		r.res = x;
		return r;
	endfunction

	// random command biased toward a small pool of patterns and pages so rules hit
	function automatic cmd_row_t rand_cmd();
		logic [7:0] pats[4] = '{8'h00, 8'h01, 8'h81, 8'hFF};
		logic [7:0] pgs[5] = '{8'd1, 8'd2, 8'd3, 8'd5, 8'd255};
		cmd_row_t r;
		int k;
		k = $urandom_range(99);
		r = mk(CMD_STEP, 8'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
		if (k < 35) r.cmd = CMD_STEP;
		else if (k < 62) r.cmd = CMD_LEARN;
		else if (k < 72) r.cmd = CMD_REM_NEAR;
		else if (k < 80) r.cmd = CMD_REM_PAGE;
		else if (k < 82) r.cmd = CMD_CLEAR;
		else if (k < 88) r.cmd = CMD_SET_OUT;
		else if (k < 96) r.cmd = CMD_SET_PAGE;
		else r.cmd = 3'd7;
		if ($urandom_range(3) != 0) r.pat = pats[$urandom_range(3)];
		if ($urandom_range(3) != 0) r.pg = pgs[$urandom_range(4)];
		if ($urandom_range(2) == 0) r.msk = 16'h000F << (4 * $urandom_range(3));
		if ($urandom_range(2) == 0)
			r.tgt = {2'($urandom_range(3)), 14'h0} | 16'($urandom_range(3));
		return r;
	endfunction

	// receiver: stall pattern plus a long hold-off when requested
	initial begin
		int hold;
		res_ch.ready <= 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off) begin
				hold = 3000;
				res_ch.ready <= 0;
				repeat (hold) @(posedge clk);
				hold_off = 0;
			end
			res_ch.ready <= ($urandom_range(7) < 5) || ($urandom_range(1) == 0 && sending_done);
		end
	end

	// result checker
	always @(posedge clk) begin
		seq_res_t got, want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got = {res_ch.status, res_ch.output_word, res_ch.current_page, res_ch.used_count};
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result %h", got);
			end else begin
				want = expected_q.pop_front();
				if (got != want) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: expected st=%0d out=%h pg=%0d n=%0d got st=%0d out=%h pg=%0d n=%0d",
							want.status, want.output_word, want.current_page, want.used_count,
							got.status, got.output_word, got.current_page, got.used_count);
				end
			end
		end
	end

	initial begin
		cmd_row_t dir[$];
		int wait_n;
		bit held, drained;
		held = 0;
		drained = 0;
		arst_n = 0;
		cmd_ch.valid <= 0;
		cmd_ch.command <= CMD_STEP;
		cmd_ch.input_pattern <= '0;
		cmd_ch.target_output <= '0;
		cmd_ch.rule_mask <= '0;
		cmd_ch.rule_page <= '0;
		for (int i = 0; i < NE; i++) begin
			tbl_page[i] = 0; tbl_edges[i] = 0; tbl_fb[i] = 0;
			tbl_mask[i] = 0; tbl_clr[i] = 0; tbl_set[i] = 0;
		end
		m_latched = 0; m_out = 0; m_page = 0; m_used = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// after reset: no edge, unused code, then learn, step, set, remove and clear rows
		dir.push_back(mkx(mk(CMD_STEP, 8'h00, '0, '0, '0), {ST_NONE, 16'h0, 8'd0, 7'd0}));
		dir.push_back(mkx(mk(3'd7, 8'hFF, 16'hFFFF, 16'hFFFF, 8'd9), {ST_NONE, 16'h0, 8'd0, 7'd0}));
		dir.push_back(mkx(mk(CMD_LEARN, 8'hFF, 16'hFFFF, 16'hFFFF, 8'd0), {ST_NONE, 16'h0, 8'd0, 7'd0}));
		dir.push_back(mkx(mk(CMD_LEARN, 8'hFF, 16'hFFFF, 16'hFFFF, 8'd1), {ST_STORED, 16'h0, 8'd0, 7'd1}));
		dir.push_back(mkx(mk(CMD_LEARN, 8'hFF, 16'h1234, 16'h00FF, 8'd1), {ST_EXISTS, 16'h0, 8'd0, 7'd1}));
		dir.push_back(mkx(mk(CMD_STEP, 8'hFF, '0, '0, '0), {ST_GLOBAL, 16'hFFFF, 8'd1, 7'd1}));
		dir.push_back(mk(CMD_STEP, 8'h00, '0, '0, '0));
		dir.push_back(mkx(mk(CMD_SET_OUT, '0, 16'h0000, '0, '0), {ST_DONE, 16'h0, 8'd1, 7'd1}));
		dir.push_back(mkx(mk(CMD_SET_PAGE, '0, '0, '0, 8'd255), {ST_DONE, 16'h0, 8'd255, 7'd1}));
		dir.push_back(mk(CMD_LEARN, 8'h01, 16'h00F0, 16'h00FF, 8'd255));
		dir.push_back(mk(CMD_LEARN, 8'h01, 16'h000F, 16'h00FF, 8'd3));
		dir.push_back(mk(CMD_LEARN, 8'h01, 16'h0F00, 16'h0F00, 8'd2));
		dir.push_back(mk(CMD_STEP, 8'h01, '0, '0, '0));
		dir.push_back(mk(CMD_SET_PAGE, '0, '0, '0, 8'd0));
		dir.push_back(mk(CMD_SET_OUT, '0, 16'h0000, '0, '0));
		dir.push_back(mk(CMD_STEP, 8'h00, '0, '0, '0));
		dir.push_back(mk(CMD_STEP, 8'h01, '0, '0, '0));
		dir.push_back(mk(CMD_REM_NEAR, 8'h00, '0, '0, '0));
		dir.push_back(mk(CMD_REM_PAGE, 8'h00, '0, '0, 8'd1));
		dir.push_back(mk(CMD_REM_PAGE, 8'h00, '0, '0, 8'd0));
		dir.push_back(mk(CMD_REM_PAGE, 8'h00, '0, 16'hFFFF, 8'd255));
		dir.push_back(mkx(mk(CMD_CLEAR, '0, '0, '0, '0), {ST_DONE, 16'h0, 8'd2, 7'd0}));
		foreach (dir[i]) send_cmd(dir[i]);

		// fill the table to reach the full status; only every other item carries an edge
		for (int i = 0; i < 2 * NE + 4; i++)
			send_cmd(mk(CMD_LEARN, (i % 2) ? 8'h00 : 8'h01, 16'($urandom), 16'($urandom),
				8'(2 + i)));
		send_cmd(mk(CMD_CLEAR, '0, '0, '0, '0));

		for (int n = 0; n < 1400; ) begin
			int burst;
			burst = $urandom_range(1, 30);
			if (!held && n > 300) begin
				hold_off = 1;
				held = 1;
			end
			if (!drained && n > 700) begin
				drained = 1;
				cmd_ch.valid <= 0;
				wait (expected_q.size() == 0);
				@(posedge clk);
			end
			for (int b = 0; b < burst; b++) begin
				send_cmd(rand_cmd());
				n++;
			end
			if ($urandom_range(2) != 0) idle_cycles($urandom_range(1, 200));
		end
		cmd_ch.valid <= 0;
		sending_done = 1;
		wait_n = 0;
		while (expected_q.size() != 0 && wait_n < 2000000) begin
			@(posedge clk);
			wait_n++;
		end
		repeat (300) @(posedge clk);
		if (errors == 0 && expected_q.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
